>>> src/vgpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel grid point de-duplicator package
// Shared widths, codes and command/status types for the de-duplicator.
// ----------------------------------------------------------------------------
package vgpd_pkg;

   localparam int KeySlots  = 8192;
   localparam int MaxKept   = 4096;
   localparam int AxisBits  = 21;
   localparam int SlotBits  = $clog2(KeySlots);
   localparam int CountBits = 13;
   localparam int KeyBits   = 3 * AxisBits;
   localparam int CoordBits = 24;
   localparam int SizeBits  = 16;
   localparam int CsrIdxBits  = 1;
   localparam int CsrDataBits = 16;
   localparam int EpochBits = 8;

   localparam logic [AxisBits-1:0] AxisBias = AxisBits'(1 << 20);
   localparam logic [31:0] HashMult = 32'd2654435761;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_EDGE_LEN  = 1'b0,
      CSR_POINT_CAP = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_KEPT      = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_DROPPED   = 2'd2,
      ST_CLEARED   = 2'd3
   } status_type;

   typedef struct packed {
      logic     [0:0] op;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
      logic signed [CoordBits-1:0] coord_z;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [KeyBits-1:0]   voxel_key;
      logic signed [CoordBits-1:0] out_x;
      logic signed [CoordBits-1:0] out_y;
      logic signed [CoordBits-1:0] out_z;
      logic [CountBits-1:0] kept_count;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the request word
      logic div_start;  // start the three floor divisions
      logic hash;       // compute the home slot from the key
      logic rd;         // issue a table read at the probe slot
      logic step;       // advance probe slot
      logic insert;     // write key at probe slot and count it
      logic clear;      // open a new epoch and zero the count
      logic wipe;       // write an invalid mark to the wipe slot (after reset and on epoch wrap)
      logic [1:0] status;
      logic set_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic div_done;
      logic capped;
      logic slot_free;
      logic key_match;
      logic probe_last;
      logic wipe_last;
      logic epoch_wrap;
   } dp_sts_type;

   function automatic logic [SlotBits-1:0] slot_of(input logic [KeyBits-1:0] key);
      logic [AxisBits-1:0] h;
      logic [AxisBits+31:0] p;
      h = key[AxisBits-1:0] ^ key[2*AxisBits-1:AxisBits] ^ key[KeyBits-1:2*AxisBits];
      p = (AxisBits+32)'(h) * (AxisBits+32)'(HashMult);
      return p[8 +: SlotBits];
   endfunction

endpackage
`default_nettype wire

>>> src/vgpd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word of a payload type from source to sink.
// ----------------------------------------------------------------------------
interface vgpd_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/vgpd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Floor divider
// Restoring divider, one quotient bit per cycle, giving the biased 21-bit
// voxel index of a signed coordinate.
// ----------------------------------------------------------------------------
module vgpd_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [vgpd_pkg::CoordBits-1:0] coord,
   input  wire logic [vgpd_pkg::SizeBits-1:0]   size,
   output logic                                 done,
   output logic [vgpd_pkg::AxisBits-1:0]        index
);
   import vgpd_pkg::*;

   localparam int MagBits = CoordBits;
   localparam int CntBits = $clog2(MagBits + 1);

   logic [MagBits-1:0]  quo_ff, quo_in;
   logic [SizeBits:0]   rem_ff, rem_in;
   logic [SizeBits-1:0] dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [SizeBits:0]   trial;
   logic [MagBits-1:0]  mag;
   logic [MagBits-1:0]  q_adj;

   assign mag = coord[CoordBits-1] ? MagBits'(-coord) : MagBits'(coord);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         quo_in  = mag;
         rem_in  = '0;
         dvs_in  = (size == '0) ? SizeBits'(1) : size;
         neg_in  = coord[CoordBits-1];
         cnt_in  = CntBits'(MagBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[SizeBits-1:0], quo_ff[MagBits-1]};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[MagBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[MagBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // Floor of a negative quotient: -(q) less one when there is a remainder.
   assign q_adj = neg_ff ? ((rem_ff != '0) ? ~quo_ff : -quo_ff) : quo_ff;
   assign done  = !busy_ff && (cnt_ff == '0);
   assign index = q_adj[AxisBits-1:0] + AxisBias;

endmodule
`default_nettype wire

>>> src/vgpd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// De-duplicator datapath
// Key building, hash, probe table with epoch marks, kept count and
// result register.
// ----------------------------------------------------------------------------
module vgpd_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire vgpd_pkg::dp_cmd_type       cmd,
   output vgpd_pkg::dp_sts_type            sts,
   input  wire vgpd_pkg::req_word_type     req_word,
   input  wire logic [vgpd_pkg::SizeBits-1:0]  edge_len,
   input  wire logic [vgpd_pkg::CountBits-1:0] point_cap,
   output vgpd_pkg::rsp_word_type          rsp_word
);
   import vgpd_pkg::*;

   req_word_type        word_ff;
   logic [KeyBits-1:0]  key_ff, key_in;
   logic [SlotBits-1:0] slot_ff, slot_in;
   logic [SlotBits:0]   probes_ff, probes_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [EpochBits-1:0] epoch_ff, epoch_in;
   logic [SlotBits-1:0] wipe_ff, wipe_in;
   logic [1:0]          status_ff;
   logic [CountBits-1:0] cap_eff;
   logic [AxisBits-1:0] ix, iy, iz;
   logic                dx, dy, dz;

   // Table: each entry holds the key and the epoch it was written in.
   logic [KeyBits+EpochBits-1:0] mem [KeySlots];
   logic [KeyBits+EpochBits-1:0] rd_ff;

   vgpd_div u_div_x (.clock, .reset, .start(cmd.div_start), .coord(word_ff.coord_x),
                     .size(edge_len), .done(dx), .index(ix));
   vgpd_div u_div_y (.clock, .reset, .start(cmd.div_start), .coord(word_ff.coord_y),
                     .size(edge_len), .done(dy), .index(iy));
   vgpd_div u_div_z (.clock, .reset, .start(cmd.div_start), .coord(word_ff.coord_z),
                     .size(edge_len), .done(dz), .index(iz));

   assign cap_eff = (point_cap < CountBits'(MaxKept)) ? point_cap : CountBits'(MaxKept);

   always_comb begin
      key_in    = key_ff;
      slot_in   = slot_ff;
      probes_in = probes_ff;
      count_in  = count_ff;
      epoch_in  = epoch_ff;
      wipe_in   = wipe_ff;
      if (cmd.div_start) key_in = '0;
      if (cmd.hash) begin
         key_in    = {ix, iy, iz};
         slot_in   = slot_of({ix, iy, iz});
         probes_in = '0;
      end
      if (cmd.step) begin
         slot_in   = slot_ff + SlotBits'(1);
         probes_in = probes_ff + (SlotBits+1)'(1);
      end
      if (cmd.insert) count_in = count_ff + CountBits'(1);
      if (cmd.clear) begin
         count_in = '0;
         // Epoch zero marks a wiped entry, so the epoch skips it on wrapping.
         epoch_in = (epoch_ff == '1) ? EpochBits'(1) : epoch_ff + EpochBits'(1);
      end
      if (cmd.wipe) wipe_in = wipe_ff + SlotBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         epoch_ff <= EpochBits'(1);
         wipe_ff  <= '0;
      end else begin
         count_ff <= count_in;
         epoch_ff <= epoch_in;
         wipe_ff  <= wipe_in;
      end
      key_ff    <= key_in;
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      if (cmd.load) word_ff <= req_word;
      if (cmd.set_status) status_ff <= cmd.status;
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wipe) mem[wipe_ff] <= '0;
      else if (cmd.insert) mem[slot_ff] <= {key_ff, epoch_ff};
      if (cmd.rd) rd_ff <= mem[slot_ff];
   end

   // Epoch zero is never current, so wiped entries read as free.
   assign sts.is_clear   = word_ff.op[0];
   assign sts.div_done   = dx && dy && dz;
   assign sts.capped     = !(count_ff < cap_eff);
   assign sts.slot_free  = rd_ff[EpochBits-1:0] != epoch_ff;
   assign sts.key_match  = rd_ff[KeyBits+EpochBits-1:EpochBits] == key_ff;
   assign sts.probe_last = probes_ff == (SlotBits+1)'(KeySlots - 1);
   assign sts.wipe_last  = wipe_ff == SlotBits'(KeySlots - 1);
   assign sts.epoch_wrap = epoch_ff == '1;

   always_comb begin
      rsp_word.status     = status_ff;
      rsp_word.kept_count = count_ff;
      if (status_ff == ST_CLEARED) begin
         rsp_word.voxel_key = '0;
         rsp_word.out_x     = '0;
         rsp_word.out_y     = '0;
         rsp_word.out_z     = '0;
      end else begin
         rsp_word.voxel_key = key_ff;
         rsp_word.out_x     = word_ff.coord_x;
         rsp_word.out_y     = word_ff.coord_y;
         rsp_word.out_z     = word_ff.coord_z;
      end
   end

endmodule
`default_nettype wire

>>> src/vgpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// De-duplicator controller
// Sequences division, hashing, probing, insertion and clearing.
// ----------------------------------------------------------------------------
module vgpd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output vgpd_pkg::dp_cmd_type      cmd,
   input  wire vgpd_pkg::dp_sts_type sts
);
   import vgpd_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DECODE= 10'b0000000010,
      S_DIV   = 10'b0000000100,
      S_HASH  = 10'b0000001000,
      S_READ  = 10'b0000010000,
      S_CHECK = 10'b0000100000,
      S_WIPE  = 10'b0001000000,
      S_RESP  = 10'b0010000000,
      S_START = 10'b0100000000,
      S_INIT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         // The table contents are unknown after reset, so sweep it once.
         S_INIT: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_clear) begin
               cmd.clear      = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_CLEARED;
               // The epoch mark is about to wrap: wipe the table first.
               state_in = sts.epoch_wrap ? S_WIPE : S_RESP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_START;
            end
         end
         S_START: state_in = S_DIV;
         S_DIV: if (sts.div_done) state_in = S_HASH;
         S_HASH: begin
            cmd.hash = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.capped) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_DROPPED;
               state_in       = S_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.slot_free) begin
               cmd.insert     = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_KEPT;
               state_in       = S_RESP;
            end else if (sts.key_match) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_DUPLICATE;
               state_in       = S_RESP;
            end else if (sts.probe_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_DROPPED;
               state_in       = S_RESP;
            end else begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end
         end
         S_WIPE: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> src/voxel_grid_point_dedup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel grid point de-duplicator
// Keeps the first point of each voxel and reports every point's fate.
// ----------------------------------------------------------------------------
// One word at a time. A point is decoded, starts the three bit-serial floor
// divisions, which run side by side, is hashed, then probes the key table,
// each probe a read and a check, and then its result is handed over. A capped
// point skips the probes. A clear opens a new epoch and zeroes the count;
// every 255th clear also sweeps the 8192-entry table, one entry a cycle,
// because the per-entry epoch mark wraps. After reset the table is swept
// once in the same way, so no word is taken until that sweep ends.
module voxel_grid_point_dedup_top (
   input  wire logic clock,
   input  wire logic reset,
   vgpd_if.sink     req,
   vgpd_if.source   rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [vgpd_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [vgpd_pkg::CsrDataBits-1:0]    csr_write_data
);
   import vgpd_pkg::*;

   logic [SizeBits-1:0]  size_ff;
   logic [CountBits-1:0] cap_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;
   rsp_word_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeBits'(50);
         cap_ff  <= CountBits'(4096);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_EDGE_LEN:  size_ff <= csr_write_data[SizeBits-1:0];
            CSR_POINT_CAP: cap_ff  <= csr_write_data[CountBits-1:0];
            default: ;
         endcase
      end
   end

   vgpd_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .sts
   );

   vgpd_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .req_word(req.data), .edge_len(size_ff), .point_cap(cap_ff),
      .rsp_word
   );

   assign rsp.data = rsp_word;

endmodule
`default_nettype wire

>>> src/vgpd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// De-duplicator port checker
// Checks result words against the handshakes seen at the top level.
// ----------------------------------------------------------------------------
module vgpd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [vgpd_pkg::CountBits-1:0] rsp_kept_count,
   input wire logic [vgpd_pkg::KeyBits-1:0] rsp_voxel_key
);
   import vgpd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CLEARED |-> rsp_kept_count == '0 && rsp_voxel_key == '0)
      else $error("clear result not zero");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result before any work");

endmodule

bind voxel_grid_point_dedup_top vgpd_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status), .rsp_kept_count(rsp.data.kept_count),
   .rsp_voxel_key(rsp.data.voxel_key)
);
`default_nettype wire
